[rtl/core/cspl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_pkg
// Shared types and constants of the curve subdivision block.
// ----------------------------------------------------------------------------
package cspl_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 24;
  localparam int unsigned POS_W          = 11;
  localparam int unsigned QUEUE_DEPTH    = 2;
  // most results one accepted point can cause (closed curve end)
  localparam int unsigned MAX_CMDS       = 5;

  // register index on the APB port
  localparam int unsigned REG_CLOSED_LOOP = 0;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_EDGE,
    OP_SMOOTH
  } op_e;

  // control part of a command sent from front to back
  typedef struct packed {
    op_e              op;
    logic [POS_W-1:0] pos;
    logic             done;
  } cmd_ctl_t;

endpackage

[rtl/core/cspl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_pt_if / cspl_res_if
// Valid/ready channels for input points and produced points.
// ----------------------------------------------------------------------------
interface cspl_pt_if import cspl_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         final_point;

  modport source (output valid, point_x, point_y, point_z, final_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, final_point, output ready);
endinterface

interface cspl_res_if import cspl_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic [POS_W-1:0]             position;
  logic                         curve_done;

  modport source (output valid, out_x, out_y, out_z, position, curve_done, input ready);
  modport sink   (input valid, out_x, out_y, out_z, position, curve_done, output ready);
endinterface

[rtl/core/cspl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_front
// Accepts points, tracks curve state and issues one command per cycle while the queue is not full.
// ----------------------------------------------------------------------------
module cspl_front import cspl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned CMD_W     = $bits(cmd_ctl_t) + 9 * COORD_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             closed_loop_i,
  cspl_pt_if.sink          pt_i,
  output logic             push_o,
  output logic [CMD_W-1:0] push_data_o,
  input  logic             full_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned STEP_W = $clog2(MAX_CMDS + 1);

  typedef logic [2:0][COORD_BITS-1:0] pt_t;

  typedef enum logic [2:0] {
    SEL_FIRST,
    SEL_SECOND,
    SEL_OLDER,
    SEL_NEWER,
    SEL_CUR
  } sel_e;

  typedef struct packed {
    op_e              op;
    sel_e             sa;
    sel_e             sb;
    sel_e             sc;
    logic [POS_W-1:0] pos;
    logic             done;
  } desc_t;

  function automatic desc_t mk(input op_e op, input sel_e a, input sel_e b, input sel_e c,
                               input logic [POS_W-1:0] pos, input logic done);
    desc_t d;
    d.op   = op;
    d.sa   = a;
    d.sb   = b;
    d.sc   = c;
    d.pos  = pos;
    d.done = done;
    return d;
  endfunction

  // curve state
  pt_t              first_q, second_q, older_q, newer_q;
  logic [CNT_W-1:0] k_q, k_d;

  // request snapshot and command list
  pt_t               snap_first_q, snap_second_q, snap_older_q, snap_newer_q, snap_cur_q;
  desc_t             desc_q [MAX_CMDS];
  logic [STEP_W-1:0] cnt_q, step_q, step_d;
  logic              busy_q, busy_d;

  desc_t             lst [MAX_CMDS];
  logic [STEP_W-1:0] n;

  pt_t              cur, first_n, second_n;
  logic             accept, fin, drop, k_zero, k_one, last;
  logic [POS_W-1:0] k11, kend, pos2k, posk2;
  sel_e             end_sel, pre_sel;
  desc_t            cur_desc;

  assign cur    = {pt_i.point_z, pt_i.point_y, pt_i.point_x};
  assign fin    = pt_i.final_point;
  assign accept = pt_i.valid && pt_i.ready;

  assign drop   = k_q >= CNT_W'(MAX_POINTS);
  assign k_zero = k_q == '0;
  assign k_one  = k_q == CNT_W'(1);
  assign k11    = POS_W'(k_q);
  // a dropped final point closes the curve at the last kept point
  assign kend   = drop ? k11 - POS_W'(1) : k11;
  assign pos2k  = {k11[POS_W-2:0], 1'b0};
  assign posk2  = {kend[POS_W-2:0], 1'b0};
  assign end_sel = drop ? SEL_NEWER : SEL_CUR;
  assign pre_sel = drop ? SEL_OLDER : SEL_NEWER;

  assign first_n  = (!drop && k_zero) ? cur : first_q;
  assign second_n = (!drop && k_one) ? cur : second_q;

  always_comb begin
    for (int i = 0; i < MAX_CMDS; i++) lst[i] = '0;
    n = '0;
    if (!drop) begin
      if (k_zero) begin
        if (!closed_loop_i && !fin) begin
          lst[n] = mk(OP_PASS, SEL_CUR, SEL_CUR, SEL_CUR, '0, 1'b0);
          n = n + STEP_W'(1);
        end
      end else begin
        if (!k_one) begin
          lst[n] = mk(OP_SMOOTH, SEL_OLDER, SEL_NEWER, SEL_CUR, pos2k - POS_W'(2), 1'b0);
          n = n + STEP_W'(1);
        end
        lst[n] = mk(OP_EDGE, SEL_NEWER, SEL_CUR, SEL_CUR, pos2k - POS_W'(1), 1'b0);
        n = n + STEP_W'(1);
      end
    end
    if (fin) begin
      if (!closed_loop_i) begin
        lst[n] = mk(OP_PASS, end_sel, end_sel, end_sel, posk2, 1'b1);
        n = n + STEP_W'(1);
      end else if (!drop && k_zero) begin
        // single point loop: the point twice
        lst[n] = mk(OP_PASS, SEL_CUR, SEL_CUR, SEL_CUR, '0, 1'b0);
        n = n + STEP_W'(1);
        lst[n] = mk(OP_PASS, SEL_CUR, SEL_CUR, SEL_CUR, POS_W'(1), 1'b1);
        n = n + STEP_W'(1);
      end else begin
        lst[n] = mk(OP_SMOOTH, pre_sel, end_sel, SEL_FIRST, posk2, 1'b0);
        n = n + STEP_W'(1);
        lst[n] = mk(OP_EDGE, end_sel, SEL_FIRST, SEL_FIRST,
                    {kend[POS_W-2:0], 1'b1}, 1'b0);
        n = n + STEP_W'(1);
        lst[n] = mk(OP_SMOOTH, end_sel, SEL_FIRST, SEL_SECOND, '0, 1'b1);
        n = n + STEP_W'(1);
      end
    end
  end

  function automatic pt_t pick(input sel_e s, input pt_t f, input pt_t sc, input pt_t o,
                               input pt_t nw, input pt_t c);
    pt_t r;
    case (s)
      SEL_FIRST:  r = f;
      SEL_SECOND: r = sc;
      SEL_OLDER:  r = o;
      SEL_NEWER:  r = nw;
      default:    r = c;
    endcase
    return r;
  endfunction

  cmd_ctl_t ctl;
  pt_t      pa, pb, pc;

  assign cur_desc = desc_q[step_q];
  assign ctl.op   = cur_desc.op;
  assign ctl.pos  = cur_desc.pos;
  assign ctl.done = cur_desc.done;
  assign pa = pick(cur_desc.sa, snap_first_q, snap_second_q, snap_older_q, snap_newer_q,
                   snap_cur_q);
  assign pb = pick(cur_desc.sb, snap_first_q, snap_second_q, snap_older_q, snap_newer_q,
                   snap_cur_q);
  assign pc = pick(cur_desc.sc, snap_first_q, snap_second_q, snap_older_q, snap_newer_q,
                   snap_cur_q);
  assign push_data_o = {ctl, pc, pb, pa};

  assign last       = step_q == cnt_q - STEP_W'(1);
  assign push_o     = busy_q && !full_i;
  assign pt_i.ready = !busy_q || (push_o && last);

  always_comb begin
    k_d    = k_q;
    busy_d = busy_q;
    step_d = step_q;
    if (push_o) begin
      if (last) busy_d = 1'b0;
      else step_d = step_q + STEP_W'(1);
    end
    if (accept) begin
      busy_d = n != '0;
      step_d = '0;
      if (fin) k_d = '0;
      else if (!drop) k_d = k_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      busy_q <= 1'b0;
      step_q <= '0;
      cnt_q  <= '0;
    end else begin
      k_q    <= k_d;
      busy_q <= busy_d;
      step_q <= step_d;
      if (accept) cnt_q <= n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snap_first_q  <= first_n;
      snap_second_q <= second_n;
      snap_older_q  <= older_q;
      snap_newer_q  <= newer_q;
      snap_cur_q    <= cur;
      for (int i = 0; i < MAX_CMDS; i++) desc_q[i] <= lst[i];
      if (!drop) begin
        first_q  <= first_n;
        second_q <= second_n;
        older_q  <= newer_q;
        newer_q  <= cur;
      end
    end
  end

  a_step_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q < cnt_q))
    else $error("front step beyond command list");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pt_i.ready)
    else $error("front idle but not ready");

endmodule

[rtl/core/cspl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module cspl_queue import cspl_pkg::*; #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i) rd_q <= nxt(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CNT_W'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue underflow");

endmodule

[rtl/core/cspl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspl_back
// Executes commands: pass, edge mean or smoothing, into the output register.
// ----------------------------------------------------------------------------
module cspl_back import cspl_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned CMD_W     = $bits(cmd_ctl_t) + 9 * COORD_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [CMD_W-1:0] data_i,
  output logic             pop_o,
  cspl_res_if.source       res_o
);

  localparam int unsigned SUM_W = COORD_BITS + 4;

  typedef logic [2:0][COORD_BITS-1:0] pt_t;

  cmd_ctl_t ctl;
  pt_t      pa, pb, pc, res;
  logic signed [SUM_W-1:0] ea [3];
  logic signed [SUM_W-1:0] eb [3];
  logic signed [SUM_W-1:0] ec [3];
  logic signed [SUM_W-1:0] e_sum [3];
  logic signed [SUM_W-1:0] s_sum [3];

  logic             out_valid_q;
  pt_t              out_pt_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_done_q;

  assign pa  = data_i[3*COORD_BITS-1:0];
  assign pb  = data_i[6*COORD_BITS-1:3*COORD_BITS];
  assign pc  = data_i[9*COORD_BITS-1:6*COORD_BITS];
  assign ctl = data_i[CMD_W-1:9*COORD_BITS];

  // rounding to nearest, halves up: add half, then drop the low bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea[i]    = SUM_W'(signed'(pa[i]));
      eb[i]    = SUM_W'(signed'(pb[i]));
      ec[i]    = SUM_W'(signed'(pc[i]));
      e_sum[i] = ea[i] + eb[i] + SUM_W'(1);
      s_sum[i] = ea[i] + (eb[i] <<< 2) + (eb[i] <<< 1) + ec[i] + SUM_W'(4);
      case (ctl.op)
        OP_EDGE:   res[i] = e_sum[i][COORD_BITS:1];
        OP_SMOOTH: res[i] = s_sum[i][COORD_BITS+2:3];
        default:   res[i] = pa[i];
      endcase
    end
  end

  assign pop_o = valid_i && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_pt_q   <= res;
      out_pos_q  <= ctl.pos;
      out_done_q <= ctl.done;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_x      = out_pt_q[0];
  assign res_o.out_y      = out_pt_q[1];
  assign res_o.out_z      = out_pt_q[2];
  assign res_o.position   = out_pos_q;
  assign res_o.curve_done = out_done_q;

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |-> !pop_o)
    else $error("back popped while output stalled");

endmodule

[rtl/core/curve_subdivision_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// curve_subdivision_step
// One cubic B-spline subdivision pass over a stream of 3-D points.
// ----------------------------------------------------------------------------
// Each accepted point is turned into a list of up to five commands (kept
// point, edge mean, smoothed point) that the front issues one per cycle,
// while there is room, into a two-entry queue; the back computes each
// command and holds the result in an output register, so one result leaves
// per cycle while the output is ready. A point in the middle of a curve
// causes two commands, the first point of an open curve one, the final point
// up to five; a point may also cause none. The front takes a new point once
// the last command of the previous one is pushed. closed_loop is register 0
// at byte address 0 and is sampled for each point.
// ----------------------------------------------------------------------------
module curve_subdivision_step import cspl_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cspl_pt_if.sink     pt_i,
  cspl_res_if.source  res_o
);

  localparam int unsigned CMD_W = $bits(cmd_ctl_t) + 9 * COORD_BITS;

  logic             closed_loop_q;
  logic             cfg_sel;
  logic             push, q_full, q_valid, pop;
  logic [CMD_W-1:0] push_data, q_data;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2] == 1'(REG_CLOSED_LOOP);
  assign prdata  = cfg_sel ? {31'b0, closed_loop_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_loop_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      closed_loop_q <= pwdata[0];
    end
  end

  cspl_front #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .closed_loop_i (closed_loop_q),
    .pt_i          (pt_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (q_full)
  );

  cspl_queue #(
    .DATA_W (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  cspl_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .data_i  (q_data),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule
